>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/mpbd_pkg.sv
// ----------------------------------------------------------------------------
// mpbd_pkg
// Types and constants shared by the mipmap pyramid box downsampler.
// ----------------------------------------------------------------------------
package mpbd_pkg;

    localparam int DEF_MAX_WIDTH = 4096;
    localparam int DEF_LEVELS    = 12;

    localparam int CFG_W   = 13;   // image size registers
    localparam int CNT_W   = 13;   // position counters inside a stage
    localparam int CH_W    = 8;    // one color channel
    localparam int PSUM_W  = 9;    // sum of two channel values
    localparam int LEVEL_W = 4;
    localparam int POS_W   = 11;

    localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(256);
    localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(256);

    typedef enum logic {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } reg_index_t;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } rgb_t;

    typedef struct packed {
        logic [PSUM_W-1:0] red;
        logic [PSUM_W-1:0] green;
        logic [PSUM_W-1:0] blue;
    } psum_t;

    // one result slot of the bundle that travels with a pixel
    typedef struct packed {
        logic             hit;
        logic [POS_W-1:0] col;
        logic [POS_W-1:0] row;
        rgb_t             color;
    } slot_t;

    // pixel handed from one cell to the next
    typedef struct packed {
        logic valid;
        logic act;
        rgb_t pix;
    } link_t;

    typedef struct packed {
        logic adv;
        logic clear;
    } ctrl_t;

endpackage

>>> design/mpbd_ram.sv
// ----------------------------------------------------------------------------
// mpbd_ram
// Simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module mpbd_ram #(
    parameter int WIDTH  = 27,
    parameter int DEPTH  = 2048,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> design/mpbd_cell.sv
// ----------------------------------------------------------------------------
// mpbd_cell
// One pyramid stage: takes level STAGE pixels, emits level STAGE+1 pixels.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mpbd_cell #(
    parameter int STAGE     = 0,
    parameter int LEVELS    = 12,
    parameter int MAX_WIDTH = 4096
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  mpbd_pkg::ctrl_t                   ctrl,
    input  logic [mpbd_pkg::CFG_W-1:0]        image_width,
    input  logic [mpbd_pkg::CFG_W-1:0]        image_height,
    input  mpbd_pkg::link_t                   link_in,
    input  mpbd_pkg::slot_t [LEVELS-1:0]      bundle_in,
    output mpbd_pkg::link_t                   link_out,
    output mpbd_pkg::slot_t [LEVELS-1:0]      bundle_out
);
    import mpbd_pkg::*;

    localparam int DEPTH_RAW = MAX_WIDTH >> (STAGE + 1);
    localparam int AW        = (DEPTH_RAW > 1) ? $clog2(DEPTH_RAW) : 1;
    localparam int DEPTH     = 2 ** AW;

    logic [CNT_W-1:0] col_reg, col_next;
    logic [CNT_W-1:0] row_reg, row_next;
    rgb_t             left_reg;

    logic              v_reg;
    logic              prod_reg;
    psum_t             psum_reg;
    logic [POS_W-1:0]  colo_reg;
    logic [POS_W-1:0]  rowo_reg;
    slot_t [LEVELS-1:0] bundle_reg;

    logic [CNT_W-1:0] wk, hk;
    logic             level_on, go, in_range, odd_c, odd_r;
    logic [CNT_W:0]   col_inc, row_inc;
    psum_t            psum, rd_data;
    logic [AW-1:0]    addr;
    rgb_t             avg;
    logic [PSUM_W:0]  tot_r, tot_g, tot_b;

    assign wk       = image_width >> STAGE;
    assign hk       = image_height >> STAGE;
    assign level_on = (image_width >> (STAGE + 1)) != '0;
    assign go       = ctrl.adv && link_in.valid && link_in.act && level_on;
    assign in_range = (col_reg < (wk & ~CNT_W'(1))) && (row_reg < (hk & ~CNT_W'(1)));
    assign odd_c    = col_reg[0];
    assign odd_r    = row_reg[0];
    assign addr     = AW'(col_reg >> 1);

    assign psum.red   = PSUM_W'(left_reg.red)   + PSUM_W'(link_in.pix.red);
    assign psum.green = PSUM_W'(left_reg.green) + PSUM_W'(link_in.pix.green);
    assign psum.blue  = PSUM_W'(left_reg.blue)  + PSUM_W'(link_in.pix.blue);

    // advance or clear the raster position, wrapping at the level size
    always_comb
    begin
        col_inc  = {1'b0, col_reg} + (CNT_W + 1)'(1);
        row_inc  = {1'b0, row_reg} + (CNT_W + 1)'(1);
        col_next = col_reg;
        row_next = row_reg;
        if (ctrl.clear)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (go)
        begin
            if (col_inc >= {1'b0, wk})
            begin
                col_next = '0;
                row_next = (row_inc >= {1'b0, hk}) ? '0 : row_inc[CNT_W-1:0];
            end
            else
            begin
                col_next = col_inc[CNT_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            v_reg    <= 1'b0;
            prod_reg <= 1'b0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            if (ctrl.adv)
            begin
                v_reg    <= link_in.valid;
                prod_reg <= go && in_range && odd_c && odd_r;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (go && in_range && !odd_c)
        begin
            left_reg <= link_in.pix;
        end
        if (ctrl.adv)
        begin
            psum_reg   <= psum;
            colo_reg   <= POS_W'(col_reg >> 1);
            rowo_reg   <= POS_W'(row_reg >> 1);
            bundle_reg <= bundle_in;
        end
    end

    // pair sums of even rows, one entry per output column
    mpbd_ram #(
        .WIDTH ($bits(psum_t)),
        .DEPTH (DEPTH),
        .ADDR_W(AW)
    ) u_pair_ram (
        .clk    (clk),
        .wr_en  (go && in_range && odd_c && !odd_r),
        .wr_addr(addr),
        .wr_data(psum),
        .rd_en  (ctrl.adv),
        .rd_addr(addr),
        .rd_data(rd_data)
    );

    // rounded 2x2 average
    assign tot_r = (PSUM_W + 1)'(rd_data.red)   + (PSUM_W + 1)'(psum_reg.red)   + (PSUM_W + 1)'(2);
    assign tot_g = (PSUM_W + 1)'(rd_data.green) + (PSUM_W + 1)'(psum_reg.green) + (PSUM_W + 1)'(2);
    assign tot_b = (PSUM_W + 1)'(rd_data.blue)  + (PSUM_W + 1)'(psum_reg.blue)  + (PSUM_W + 1)'(2);
    assign avg.red   = tot_r[PSUM_W:2];
    assign avg.green = tot_g[PSUM_W:2];
    assign avg.blue  = tot_b[PSUM_W:2];

    assign link_out.valid = v_reg;
    assign link_out.act   = prod_reg;
    assign link_out.pix   = avg;

    always_comb
    begin
        bundle_out              = bundle_reg;
        bundle_out[STAGE].hit   = prod_reg;
        bundle_out[STAGE].col   = colo_reg;
        bundle_out[STAGE].row   = rowo_reg;
        bundle_out[STAGE].color = avg;
    end

    `ASSERT_IMPLIES(a_prod_has_item, prod_reg, v_reg, "result flagged without an item")
    `ASSERT_NEXT(a_clear_pos, ctrl.clear, col_reg == '0 && row_reg == '0,
                 "position not cleared by register write")
    `ASSERT_NEXT(a_hold_pos, !ctrl.adv && !ctrl.clear,
                 $stable(col_reg) && $stable(row_reg), "position moved while stalled")

endmodule

>>> design/mpbd_serializer.sv
// ----------------------------------------------------------------------------
// mpbd_serializer
// Unpack a result bundle into output beats, lowest level first.
// ----------------------------------------------------------------------------
module mpbd_serializer #(
    parameter int LEVELS = 12
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         tail_valid,
    input  mpbd_pkg::slot_t [LEVELS-1:0] bundle_in,
    output logic                         take,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [mpbd_pkg::LEVEL_W-1:0] out_level,
    output mpbd_pkg::slot_t              out_slot,
    output logic                         out_last
);
    import mpbd_pkg::*;

    localparam int IDX_W  = $clog2(LEVELS + 1);
    localparam int SLOT_W = (LEVELS > 1) ? $clog2(LEVELS) : 1;

    logic               busy_reg, busy_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    slot_t [LEVELS-1:0] bundle_reg;
    logic [LEVELS:0]    hits;
    logic [IDX_W-1:0]   idx_inc;

    always_comb
    begin
        hits[LEVELS] = 1'b0;
        for (int i = 0; i < LEVELS; i++)
        begin
            hits[i] = bundle_reg[i].hit;
        end
    end

    assign idx_inc   = IDX_W'(idx_reg + IDX_W'(1));
    assign out_last  = !hits[idx_inc];
    assign out_valid = busy_reg;
    assign out_slot  = bundle_reg[idx_reg[SLOT_W-1:0]];
    assign out_level = LEVEL_W'(idx_inc);
    assign take      = !busy_reg || (out_ready && out_last);

    always_comb
    begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (tail_valid && take)
        begin
            busy_next = bundle_in[0].hit;
            idx_next  = '0;
        end
        else if (busy_reg && out_ready)
        begin
            if (out_last)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                idx_next = idx_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tail_valid && take)
        begin
            bundle_reg <= bundle_in;
        end
    end

endmodule

>>> design/mipmap_pyramid_box_downsampler.sv
// ----------------------------------------------------------------------------
// mipmap_pyramid_box_downsampler
// Streaming mipmap pyramid builder with a 2x2 rounded box filter.
// ----------------------------------------------------------------------------
// Base-image RGB pixels enter one per beat in row-major order and the block
// emits every pyramid pixel they complete (level 1 = half size, up to LEVELS
// levels, floor(log2(image_width)) of them), lowest level first, with tlast
// on the final beat that one input pixel causes. Odd last columns and rows
// of any level are dropped; each output channel is (sum of four + 2) >> 2.
// The pyramid is a row of LEVELS cells, one per level; every input pixel
// walks the whole row, one cell per cycle while the row is not held, and
// collects its results in a bundle. The input takes one pixel per cycle;
// it stalls only while the output serializer still owes beats, since one
// pixel that closes blocks on several levels causes that many output beats,
// at one beat per cycle while m_tready is high. Each cell keeps a pair-sum
// RAM of MAX_WIDTH >> (level+1) entries; no clearing pass is needed after
// reset. Writing image_width or image_height restarts the image at pixel
// (0,0); write them only while the block is idle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mipmap_pyramid_box_downsampler #(
    parameter int MAX_WIDTH = mpbd_pkg::DEF_MAX_WIDTH,
    parameter int LEVELS    = mpbd_pkg::DEF_LEVELS
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // base pixels
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // red_in[7:0], green_in[15:8], blue_in[23:16]
    // pyramid pixels
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // level[3:0], col[14:4], row[25:15], red_out[33:26],
                                   // green_out[41:34], blue_out[49:42], zero[55:50]
    output logic        m_tlast
);
    import mpbd_pkg::*;

    logic [CFG_W-1:0] width_reg, height_reg;
    logic             cfg_wr;
    ctrl_t            ctrl;

    link_t              link   [LEVELS+1];
    slot_t [LEVELS-1:0] bundle [LEVELS+1];

    logic             ser_take;
    logic [LEVEL_W-1:0] out_level;
    slot_t            out_slot;

    // ---------------- configuration registers ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (reg_index_t'(paddr[2]))
                REG_IMAGE_WIDTH:  width_reg  <= pwdata[CFG_W-1:0];
                REG_IMAGE_HEIGHT: height_reg <= pwdata[CFG_W-1:0];
                default:          width_reg  <= width_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_index_t'(paddr[2]))
            REG_IMAGE_WIDTH:  prdata = 32'(width_reg);
            REG_IMAGE_HEIGHT: prdata = 32'(height_reg);
            default:          prdata = '0;
        endcase
    end

    // ---------------- cell row ----------------
    // The whole row moves together; hold it only when the tail bundle
    // cannot be handed to the serializer.
    assign ctrl.adv   = !link[LEVELS].valid || ser_take;
    assign ctrl.clear = cfg_wr;
    assign s_tready   = ctrl.adv;

    // Every accepted pixel feeds level 0; later cells only see it if the
    // cell before completed a block.
    assign link[0].valid     = s_tvalid;
    assign link[0].act       = 1'b1;
    assign link[0].pix.red   = s_tdata[7:0];
    assign link[0].pix.green = s_tdata[15:8];
    assign link[0].pix.blue  = s_tdata[23:16];
    assign bundle[0]         = '0;

    for (genvar k = 0; k < LEVELS; k++)
    begin : g_cell
        mpbd_cell #(
            .STAGE    (k),
            .LEVELS   (LEVELS),
            .MAX_WIDTH(MAX_WIDTH)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .image_width (width_reg),
            .image_height(height_reg),
            .link_in     (link[k]),
            .bundle_in   (bundle[k]),
            .link_out    (link[k+1]),
            .bundle_out  (bundle[k+1])
        );
    end

    // ---------------- output ----------------
    // Drop bundles with no results; unpack the rest one level per beat.
    mpbd_serializer #(
        .LEVELS(LEVELS)
    ) u_ser (
        .clk       (clk),
        .rst_n     (rst_n),
        .tail_valid(link[LEVELS].valid),
        .bundle_in (bundle[LEVELS]),
        .take      (ser_take),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_level (out_level),
        .out_slot  (out_slot),
        .out_last  (m_tlast)
    );

    assign m_tdata = {6'b0, out_slot.color.blue, out_slot.color.green, out_slot.color.red,
                      out_slot.row, out_slot.col, out_level};

    // Input stalls only while the serializer still owes beats.
    `ASSERT_IMPLIES(a_stall_cause, !s_tready, m_tvalid && !(m_tready && m_tlast),
                    "input stalled without pending output")
    // Within one pixel's results the level climbs by one.
    `ASSERT_NEXT(a_level_step, m_tvalid && m_tready && !m_tlast,
                 m_tvalid && (out_level == $past(out_level) + 4'd1),
                 "level did not advance within a pixel's results")
    // A new pixel's results always start at level 1.
    `ASSERT_NEXT(a_level_start, m_tvalid && m_tready && m_tlast,
                 !m_tvalid || out_level == 4'd1, "result run did not start at level 1")

endmodule
